// ----- rtl/voxel_face_culling_mesher_unit_assert.svh -----
// Assertion macros for the voxel face culling mesher.
// Used by the top level only; needs signals named clock and reset in scope.
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_ASSERT_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_ASSERT_SVH
`ifndef SYNTH
// checked property, ignored while reset is high
`define VFCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked property, also during reset
`define VFCM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define VFCM_ASSERT(label, prop, msg)
`define VFCM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/vfcm_pkg.sv -----
// Shared constants for the voxel face culling mesher.
// No dependencies.
package vfcm_pkg;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 4;
   localparam int SIDE_W = 3;
   localparam int TYPE_W = 8;
   localparam int TEX_W  = 8;
   localparam int FNUM_W = 15;
   localparam int NBR_W  = 6;

   localparam logic [FNUM_W-1:0] FNUM_MAX = '1;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD_VOXEL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_NBR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_TEX   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MESH       = 3'd4;

   // face sides
   localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd4;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd5;
endpackage

// ----- rtl/vfcm_req_if.sv -----
// Command channel interface of the mesher.
// Depends on vfcm_pkg.
interface vfcm_req_if;
   import vfcm_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  x_pos;
   logic [POS_W-1:0]  y_pos;
   logic [POS_W-1:0]  z_pos;
   logic [SIDE_W-1:0] side;
   logic              solid;
   logic [TYPE_W-1:0] block_type;
   logic [TEX_W-1:0]  texture;

   modport source (output valid, command, x_pos, y_pos, z_pos, side, solid,
                   block_type, texture, input ready);
   modport sink (input valid, command, x_pos, y_pos, z_pos, side, solid,
                 block_type, texture, output ready);
endinterface

// ----- rtl/vfcm_rsp_if.sv -----
// Face result channel interface of the mesher.
// Depends on vfcm_pkg.
interface vfcm_rsp_if;
   import vfcm_pkg::*;
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  face_x;
   logic [POS_W-1:0]  face_y;
   logic [POS_W-1:0]  face_z;
   logic [SIDE_W-1:0] face_side;
   logic [TEX_W-1:0]  face_texture;
   logic [FNUM_W-1:0] face_number;
   logic              last;
   logic              done_res;

   modport source (output valid, face_x, face_y, face_z, face_side, face_texture,
                   face_number, last, done_res, input ready);
   modport sink (input valid, face_x, face_y, face_z, face_side, face_texture,
                 face_number, last, done_res, output ready);
endinterface

// ----- rtl/vfcm_ram.sv -----
// Generic single port RAM with registered read.
// No dependencies.
module vfcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/vfcm_nbr_step.sv -----
// Neighbor step unit: one +/-1 adder and one bound compare, shared by all sides.
// Depends on vfcm_pkg.
module vfcm_nbr_step #(
   parameter int CHUNK_SIZE = 16,
   localparam int CW = $clog2(CHUNK_SIZE)
) (
   input  logic [CW-1:0]               cx,
   input  logic [CW-1:0]               cy,
   input  logic [CW-1:0]               cz,
   input  logic [vfcm_pkg::SIDE_W-1:0] side,
   output logic [CW-1:0]               nx,
   output logic [CW-1:0]               ny,
   output logic [CW-1:0]               nz,
   output logic                        at_edge,
   output logic [CW-1:0]               pa,
   output logic [CW-1:0]               pb
);
   import vfcm_pkg::*;

   localparam logic [CW-1:0] CMAX = CW'(CHUNK_SIZE - 1);

   logic          plus;
   logic [CW-1:0] coord;
   logic [CW-1:0] stepped;

   // pick the axis and direction of this side
   always_comb begin
      plus  = 1'b0;
      coord = cx;
      case (side)
         SIDE_TOP:    begin coord = cy; plus = 1'b1; end
         SIDE_BOTTOM: begin coord = cy; plus = 1'b0; end
         SIDE_BACK:   begin coord = cz; plus = 1'b0; end
         SIDE_FRONT:  begin coord = cz; plus = 1'b1; end
         SIDE_LEFT:   begin coord = cx; plus = 1'b0; end
         SIDE_RIGHT:  begin coord = cx; plus = 1'b1; end
         default:     begin coord = cx; plus = 1'b1; end
      endcase
   end

   // shared step and edge test
   assign stepped = plus ? coord + 1'b1 : coord - 1'b1;
   assign at_edge = plus ? (coord == CMAX) : (coord == '0);

   // neighbor voxel and boundary plane coordinates
   always_comb begin
      nx = cx;
      ny = cy;
      nz = cz;
      if (side inside {SIDE_TOP, SIDE_BOTTOM}) begin
         ny = stepped;
         pa = cx;
         pb = cz;
      end else if (side inside {SIDE_BACK, SIDE_FRONT}) begin
         nz = stepped;
         pa = cx;
         pb = cy;
      end else begin
         nx = stepped;
         pa = cy;
         pb = cz;
      end
   end
endmodule

// ----- rtl/voxel_face_culling_mesher_unit.sv -----
// Top level of the voxel face culling mesher: stores, sequencer, output register.
// Depends on vfcm_pkg, vfcm_req_if, vfcm_rsp_if, vfcm_ram, vfcm_nbr_step.
//
//  channel   | dir | handshake          | carries
//  req_chan  | in  | valid/ready        | command, coordinates, side, solid, type, texture
//  rsp_chan  | out | valid/ready        | one face, or the total when done
//  csr_*     | in  | csr_we, no wait    | neighbors_present
//
// Loads, restart and unknown commands complete in idle. A mesh step past the end
// sends the total; any other reads the center voxel, and air ends it there.
// A solid voxel probes each side, directly (edge, no neighbor chunk) or by a store read
// through the shared step unit, then scans sides up to the last exposed one and emits
// each exposed face. A full result register lets idle take new items; a stalled result
// holds the sequencer. No clearing pass follows reset.
`include "voxel_face_culling_mesher_unit_assert.svh"
module voxel_face_culling_mesher_unit #(
   parameter int CHUNK_SIZE = 16,
   parameter int TYPE_COUNT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   vfcm_req_if.sink                   req_chan,
   vfcm_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [vfcm_pkg::NBR_W-1:0] csr_wdata
);
   import vfcm_pkg::*;

   localparam int CW = $clog2(CHUNK_SIZE);
   localparam int TW = $clog2(TYPE_COUNT);
   localparam logic [CW-1:0] CMAX = CW'(CHUNK_SIZE - 1);
   localparam int VOX_DEPTH = 1 << (3 * CW);
   localparam int NBR_DEPTH = 8 << (2 * CW);
   localparam int TEX_DEPTH = 8 << TW;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TOTAL  = 3'd1;
   localparam logic [2:0] ST_CENTER = 3'd2;
   localparam logic [2:0] ST_PROBE  = 3'd3;
   localparam logic [2:0] ST_TEST   = 3'd4;
   localparam logic [2:0] ST_TEX    = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic              end_ff, end_in;
   logic [FNUM_W-1:0] fcnt_ff, fcnt_in;
   logic [NBR_W-1:0]  present_ff;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [5:0]        mask_ff, mask_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [SIDE_W-1:0] rsp_side_ff, rsp_side_in;
   logic [TEX_W-1:0]  rsp_tex_ff, rsp_tex_in;
   logic [FNUM_W-1:0] rsp_fnum_ff, rsp_fnum_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              req_fire, out_free, advance, bit_set, step_side;
   logic [5:0]        mask_new, mask_rem;
   logic [CW-1:0]     ld_x, ld_y, ld_z, ld_a, ld_b;
   logic              x_ok, y_ok, z_ok, a_ok, b_ok;
   logic [CW-1:0]     nb_x, nb_y, nb_z, nb_a, nb_b;
   logic              nb_edge;

   logic                   vox_we, nbr_we, tex_we;
   logic [3*CW-1:0]        vox_addr;
   logic [2*CW+2:0]        nbr_addr;
   logic [TW+2:0]          tex_addr;
   logic [TYPE_W:0]        vox_rdata;
   logic [0:0]             nbr_rdata;
   logic [TEX_W-1:0]       tex_rdata;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // load coordinates and range checks
   assign ld_x = CW'(req_chan.x_pos);
   assign ld_y = CW'(req_chan.y_pos);
   assign ld_z = CW'(req_chan.z_pos);
   assign x_ok = {3'b000, req_chan.x_pos} < 7'(CHUNK_SIZE);
   assign y_ok = {3'b000, req_chan.y_pos} < 7'(CHUNK_SIZE);
   assign z_ok = {3'b000, req_chan.z_pos} < 7'(CHUNK_SIZE);

   always_comb begin
      if (req_chan.side inside {SIDE_TOP, SIDE_BOTTOM}) begin
         ld_a = ld_x; ld_b = ld_z; a_ok = x_ok; b_ok = z_ok;
      end else if (req_chan.side inside {SIDE_BACK, SIDE_FRONT}) begin
         ld_a = ld_x; ld_b = ld_y; a_ok = x_ok; b_ok = y_ok;
      end else begin
         ld_a = ld_y; ld_b = ld_z; a_ok = y_ok; b_ok = z_ok;
      end
   end

   vfcm_nbr_step #(.CHUNK_SIZE(CHUNK_SIZE)) u_step (
      .cx(cx_ff), .cy(cy_ff), .cz(cz_ff), .side(side_ff),
      .nx(nb_x), .ny(nb_y), .nz(nb_z), .at_edge(nb_edge), .pa(nb_a), .pb(nb_b)
   );

   // store ports: loads in idle, otherwise sequencer reads
   always_comb begin
      vox_we   = 1'b0;
      nbr_we   = 1'b0;
      tex_we   = 1'b0;
      vox_addr = {cx_ff, cz_ff, cy_ff};
      nbr_addr = {side_ff, nb_a, nb_b};
      tex_addr = {TW'(type_ff), side_ff};
      if (state_ff == ST_PROBE) begin
         vox_addr = {nb_x, nb_z, nb_y};
      end
      if (req_fire) begin
         case (req_chan.command)
            CMD_LOAD_VOXEL: begin
               vox_we   = x_ok && y_ok && z_ok;
               vox_addr = {ld_x, ld_z, ld_y};
            end
            CMD_LOAD_NBR: begin
               nbr_we   = (req_chan.side <= SIDE_RIGHT) && a_ok && b_ok;
               nbr_addr = {req_chan.side, ld_a, ld_b};
            end
            CMD_LOAD_TEX: begin
               tex_we   = (req_chan.side <= SIDE_RIGHT) &&
                          ({1'b0, req_chan.block_type} < 9'(TYPE_COUNT));
               tex_addr = {TW'(req_chan.block_type), req_chan.side};
            end
            default: ;
         endcase
      end
   end

   vfcm_ram #(.WIDTH(TYPE_W + 1), .DEPTH(VOX_DEPTH)) u_vox_ram (
      .clock(clock), .we(vox_we), .addr(vox_addr),
      .wdata({req_chan.solid, req_chan.block_type}), .rdata(vox_rdata)
   );

   vfcm_ram #(.WIDTH(1), .DEPTH(NBR_DEPTH)) u_nbr_ram (
      .clock(clock), .we(nbr_we), .addr(nbr_addr),
      .wdata(req_chan.solid), .rdata(nbr_rdata)
   );

   vfcm_ram #(.WIDTH(TEX_W), .DEPTH(TEX_DEPTH)) u_tex_ram (
      .clock(clock), .we(tex_we), .addr(tex_addr),
      .wdata(req_chan.texture), .rdata(tex_rdata)
   );

   // exposure bit of the side under probe
   always_comb begin
      bit_set = 1'b0;
      if (state_ff == ST_PROBE) begin
         bit_set = nb_edge && !present_ff[side_ff];
      end else if (state_ff == ST_TEST) begin
         bit_set = nb_edge ? !nbr_rdata[0] : !vox_rdata[TYPE_W];
      end
      mask_new = mask_ff | (6'(bit_set) << side_ff);
      mask_rem = mask_ff & ~(6'b000001 << side_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      end_in       = end_ff;
      fcnt_in      = fcnt_ff;
      type_in      = type_ff;
      side_in      = side_ff;
      mask_in      = mask_ff;
      advance      = 1'b0;
      step_side    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_tex_in   = rsp_tex_ff;
      rsp_fnum_in  = rsp_fnum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.command)
                  CMD_RESTART: begin
                     cx_in   = '0;
                     cy_in   = '0;
                     cz_in   = '0;
                     end_in  = 1'b0;
                     fcnt_in = '0;
                  end
                  CMD_MESH: begin
                     state_in = end_ff ? ST_TOTAL : ST_CENTER;
                  end
                  default: ;
               endcase
            end
         end
         ST_TOTAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_side_in  = '0;
               rsp_tex_in   = '0;
               rsp_fnum_in  = fcnt_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CENTER: begin
            if (!vox_rdata[TYPE_W]) begin
               advance  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               type_in  = vox_rdata[TYPE_W-1:0];
               side_in  = SIDE_TOP;
               mask_in  = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (nb_edge && !present_ff[side_ff]) begin
               step_side = 1'b1;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            step_side = 1'b1;
         end
         ST_TEX: begin
            if (mask_ff[side_ff]) begin
               state_in = ST_EMIT;
            end else begin
               side_in = side_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = POS_W'(cx_ff);
               rsp_y_in     = POS_W'(cy_ff);
               rsp_z_in     = POS_W'(cz_ff);
               rsp_side_in  = side_ff;
               rsp_tex_in   = ({1'b0, type_ff} < 9'(TYPE_COUNT)) ? tex_rdata : '0;
               rsp_fnum_in  = fcnt_ff;
               rsp_last_in  = (mask_rem == '0);
               rsp_done_in  = 1'b0;
               mask_in      = mask_rem;
               if (fcnt_ff != FNUM_MAX) begin
                  fcnt_in = fcnt_ff + 1'b1;
               end
               if (mask_rem == '0) begin
                  advance  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  side_in  = side_ff + 1'b1;
                  state_in = ST_TEX;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // move on to the next side, or once all six are known to emitting, or to idle if none is exposed
      if (step_side) begin
         mask_in = mask_new;
         if (side_ff == SIDE_RIGHT) begin
            side_in = SIDE_TOP;
            if (mask_new == '0) begin
               advance  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_TEX;
            end
         end else begin
            side_in  = side_ff + 1'b1;
            state_in = ST_PROBE;
         end
      end

      // cursor walk: y fastest, then z, then x
      if (advance) begin
         if (cy_ff == CMAX) begin
            cy_in = '0;
            if (cz_ff == CMAX) begin
               cz_in = '0;
               if (cx_ff == CMAX) begin
                  end_in = 1'b1;
               end else begin
                  cx_in = cx_ff + 1'b1;
               end
            end else begin
               cz_in = cz_ff + 1'b1;
            end
         end else begin
            cy_in = cy_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         end_ff       <= 1'b0;
         fcnt_ff      <= '0;
         present_ff   <= '0;
         mask_ff      <= '0;
         side_ff      <= SIDE_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         end_ff       <= end_in;
         fcnt_ff      <= fcnt_in;
         mask_ff      <= mask_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            present_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_side_ff <= rsp_side_in;
      rsp_tex_ff  <= rsp_tex_in;
      rsp_fnum_ff <= rsp_fnum_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.face_x       = rsp_x_ff;
   assign rsp_chan.face_y       = rsp_y_ff;
   assign rsp_chan.face_z       = rsp_z_ff;
   assign rsp_chan.face_side    = rsp_side_ff;
   assign rsp_chan.face_texture = rsp_tex_ff;
   assign rsp_chan.face_number  = rsp_fnum_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.done_res     = rsp_done_ff;

   // checks
   `VFCM_ASSERT(a_done_is_last, (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff, "total not last")
   `VFCM_ASSERT(a_emit_has_face, (state_ff == ST_TEX || state_ff == ST_EMIT) |-> |mask_ff, "no face")
   `VFCM_ASSERT(a_emit_side_set, (state_ff == ST_EMIT) |-> mask_ff[side_ff], "unexposed side")
   `VFCM_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (state_ff == ST_IDLE), "not idle after reset")
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the voxel face culling mesher.
// Depends on vfcm_pkg, vfcm_req_if, vfcm_rsp_if and voxel_face_culling_mesher_unit.
`timescale 1ns / 100ps
module tb;
   import vfcm_pkg::*;

   localparam int EDGE_N     = 16;
   localparam int VOXELS     = EDGE_N * EDGE_N * EDGE_N;
   localparam int TYPES      = 256;
   localparam int TYPES_USED = 4;
   localparam int SETTLE     = 40;
   localparam int HOLD_LEN   = 400;
   localparam int WDOG_MAX   = 5000;

   // commands and sides with no meaning
   localparam logic [CMD_W-1:0]  CMD_RSVD_LO  = 3'd5;
   localparam logic [CMD_W-1:0]  CMD_RSVD_HI  = 3'd7;
   localparam logic [SIDE_W-1:0] SIDE_BAD_LO  = 3'd6;
   localparam logic [SIDE_W-1:0] SIDE_BAD_HI  = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0]  fx;
      logic [POS_W-1:0]  fy;
      logic [POS_W-1:0]  fz;
      logic [SIDE_W-1:0] fside;
      logic [TEX_W-1:0]  ftex;
      logic [FNUM_W-1:0] fnum;
      logic              flast;
      logic              fdone;
   } face_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [NBR_W-1:0] csr_wdata;

   vfcm_req_if req_chan ();
   vfcm_rsp_if rsp_chan ();

   voxel_face_culling_mesher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the mesher state
   bit              shadow_solid [EDGE_N][EDGE_N][EDGE_N];   // [x][y][z]
   logic [7:0]      shadow_type  [EDGE_N][EDGE_N][EDGE_N];
   bit              shadow_plane [6][EDGE_N][EDGE_N];
   logic [7:0]      shadow_tex   [TYPES][6];
   int              mesh_cursor;
   int              face_tally;
   logic [NBR_W-1:0] nbr_present;

   face_type pending_faces[$];
   int    errors = 0;
   int    faces_seen = 0;
   int    totals_seen = 0;
   int    items_sent;
   int    src_idle_pct;
   int    sink_idle_pct;
   int    hold_stamp;
   int    hold_seen = 0;
   int    hold_left = 0;
   int    quiet_cycles = 0;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // edge face visible when the neighbor chunk is absent or its cell is air
   function automatic bit edge_open(input int s, input int x, input int y, input int z);
      int a;
      int b;
      if (!nbr_present[s]) return 1'b1;
      if (s <= 1) begin
         a = x; b = z;
      end else if (s <= 3) begin
         a = x; b = y;
      end else begin
         a = y; b = z;
      end
      return !shadow_plane[s][a][b];
   endfunction

   function automatic bit face_open(input int s, input int x, input int y, input int z);
      int m;
      m = EDGE_N - 1;
      case (s)
         SIDE_TOP:    return (y == m) ? edge_open(s, x, y, z) : !shadow_solid[x][y+1][z];
         SIDE_BOTTOM: return (y == 0) ? edge_open(s, x, y, z) : !shadow_solid[x][y-1][z];
         SIDE_BACK:   return (z == 0) ? edge_open(s, x, y, z) : !shadow_solid[x][y][z-1];
         SIDE_FRONT:  return (z == m) ? edge_open(s, x, y, z) : !shadow_solid[x][y][z+1];
         SIDE_LEFT:   return (x == 0) ? edge_open(s, x, y, z) : !shadow_solid[x-1][y][z];
         default:     return (x == m) ? edge_open(s, x, y, z) : !shadow_solid[x+1][y][z];
      endcase
   endfunction

   // update the shadow state for one command and queue the faces it yields
   task automatic predict_faces(input logic [CMD_W-1:0] cmd, input logic [3:0] x,
                                input logic [3:0] y, input logic [3:0] z,
                                input logic [2:0] side, input logic solid,
                                input logic [7:0] btype, input logic [7:0] tex);
      face_type f;
      int vx;
      int vy;
      int vz;
      int n;
      case (cmd)
         CMD_LOAD_VOXEL: begin
            shadow_solid[x][y][z] = solid;
            shadow_type[x][y][z]  = btype;
         end
         CMD_LOAD_NBR: begin
            if (side <= SIDE_RIGHT) begin
               if (side <= SIDE_BOTTOM)     shadow_plane[side][x][z] = solid;
               else if (side <= SIDE_FRONT) shadow_plane[side][x][y] = solid;
               else                         shadow_plane[side][y][z] = solid;
            end
         end
         CMD_LOAD_TEX: begin
            if (side <= SIDE_RIGHT) shadow_tex[btype][side] = tex;
         end
         CMD_RESTART: begin
            mesh_cursor = 0;
            face_tally  = 0;
         end
         CMD_MESH: begin
            if (mesh_cursor >= VOXELS) begin
               f = '0;
               f.fnum  = face_tally[FNUM_W-1:0];
               f.flast = 1'b1;
               f.fdone = 1'b1;
               pending_faces.push_back(f);
            end else begin
               vy = mesh_cursor % EDGE_N;
               vz = (mesh_cursor / EDGE_N) % EDGE_N;
               vx = mesh_cursor / (EDGE_N * EDGE_N);
               mesh_cursor++;
               n = 0;
               if (shadow_solid[vx][vy][vz]) begin
                  for (int s = 0; s < 6; s++) begin
                     if (face_open(s, vx, vy, vz)) begin
                        f = '0;
                        f.fx    = vx[3:0];
                        f.fy    = vy[3:0];
                        f.fz    = vz[3:0];
                        f.fside = s[2:0];
                        f.ftex  = shadow_tex[shadow_type[vx][vy][vz]][s];
                        f.fnum  = face_tally[FNUM_W-1:0];
                        pending_faces.push_back(f);
                        if (face_tally < int'(FNUM_MAX)) face_tally++;
                        n++;
                     end
                  end
                  if (n > 0) pending_faces[pending_faces.size()-1].flast = 1'b1;
               end
            end
         end
         default: ;
      endcase
   endtask

   // drive one command and hold it until the transfer
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [3:0] x,
                           input logic [3:0] y, input logic [3:0] z,
                           input logic [2:0] side, input logic solid,
                           input logic [7:0] btype, input logic [7:0] tex);
      if ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.x_pos      <= x;
      req_chan.y_pos      <= y;
      req_chan.z_pos      <= z;
      req_chan.side       <= side;
      req_chan.solid      <= solid;
      req_chan.block_type <= btype;
      req_chan.texture    <= tex;
      // ready is settled at the falling edge; the transfer follows at the next rise
      forever begin
         @(negedge clock);
         if (req_chan.ready === 1'b1) break;
      end
      predict_faces(cmd, x, y, z, side, solid, btype, tex);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic send_random_fields(input logic [CMD_W-1:0] cmd);
      send_cmd(cmd, 4'($urandom), 4'($urandom), 4'($urandom), 3'($urandom_range(5)),
               1'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // meshing stays in the x=0,z=0 column, so only that column and its
   // neighbor columns (x=0,z=1 and x=1,z=0) are ever read; types stay in a small set
   task automatic send_region_voxel(input int y, input int col);
      logic [3:0] vx;
      logic [3:0] vz;
      vx = (col == 2) ? 4'd1 : 4'd0;
      vz = (col == 1) ? 4'd1 : 4'd0;
      send_cmd(CMD_LOAD_VOXEL, vx, 4'(y), vz, 3'($urandom_range(7)),
               1'($urandom_range(99) < 45), 8'($urandom_range(TYPES_USED - 1)),
               8'($urandom));
   endtask

   // mesh step, or a restart once the column is used up
   task automatic send_mesh_step();
      if (mesh_cursor >= EDGE_N) send_random_fields(CMD_RESTART);
      else                       send_random_fields(CMD_MESH);
   endtask

   // stop offering, wait for all faces, then let the sequencer settle
   task automatic drain_faces();
      req_chan.valid <= 1'b0;
      while (pending_faces.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_neighbors(input logic [NBR_W-1:0] value);
      drain_faces();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      nbr_present = value;
      @(posedge clock);
   endtask

   // fill every entry a column pass can read, so none is read unwritten
   task automatic test_store_fill();
      write_neighbors('0);
      for (int c = 0; c < 3; c++)
         for (int y = 0; y < EDGE_N; y++)
            send_region_voxel(y, c);
      for (int y = 0; y < EDGE_N; y++) begin
         send_cmd(CMD_LOAD_NBR, 4'd0, 4'(y), 4'($urandom), SIDE_BACK, 1'($urandom),
                  8'($urandom), 8'($urandom));
         send_cmd(CMD_LOAD_NBR, 4'($urandom), 4'(y), 4'd0, SIDE_LEFT, 1'($urandom),
                  8'($urandom), 8'($urandom));
      end
      send_cmd(CMD_LOAD_NBR, 4'd0, 4'($urandom), 4'd0, SIDE_TOP, 1'($urandom),
               8'($urandom), 8'($urandom));
      send_cmd(CMD_LOAD_NBR, 4'd0, 4'($urandom), 4'd0, SIDE_BOTTOM, 1'($urandom),
               8'($urandom), 8'($urandom));
      for (int t = 0; t < TYPES_USED; t++)
         for (int s = 0; s < 6; s++)
            send_cmd(CMD_LOAD_TEX, 4'($urandom), 4'($urandom), 4'($urandom), 3'(s),
                     1'($urandom), 8'(t), 8'($urandom));
   endtask

   // corner voxels, a buried voxel, ignored commands and bad sides
   task automatic test_directed();
      write_neighbors(6'h3F);
      // buried voxel at y=5: every neighbor and both edge cells solid
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd5, 4'd0, SIDE_TOP, 1'b1, 8'h01, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd6, 4'd0, SIDE_TOP, 1'b1, 8'h02, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd4, 4'd0, SIDE_TOP, 1'b1, 8'h03, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd5, 4'd1, SIDE_TOP, 1'b1, 8'h00, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd1, 4'd5, 4'd0, SIDE_TOP, 1'b1, 8'h01, 8'h00);
      send_cmd(CMD_LOAD_NBR, 4'd0, 4'd5, 4'd9, SIDE_BACK, 1'b1, 8'h00, 8'h00);
      send_cmd(CMD_LOAD_NBR, 4'd9, 4'd5, 4'd0, SIDE_LEFT, 1'b1, 8'h00, 8'h00);
      // bottom and top corners of the column
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd0, 4'd0, SIDE_TOP, 1'b1, 8'h02, 8'h00);
      send_cmd(CMD_LOAD_NBR, 4'd0, 4'd0, 4'd0, SIDE_BOTTOM, 1'b0, 8'h00, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd15, 4'd0, SIDE_TOP, 1'b1, 8'h03, 8'h00);
      send_cmd(CMD_LOAD_NBR, 4'd0, 4'd0, 4'd0, SIDE_TOP, 1'b1, 8'h00, 8'h00);
      send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'd7, 4'd0, SIDE_TOP, 1'b0, 8'h55, 8'h00);
      send_cmd(CMD_LOAD_TEX, 4'd0, 4'd0, 4'd0, SIDE_RIGHT, 1'b0, 8'hFF, 8'hFF);
      send_cmd(CMD_LOAD_TEX, 4'd0, 4'd0, 4'd0, SIDE_TOP, 1'b0, 8'h00, 8'h5A);
      // side codes above five must leave the stores alone
      send_cmd(CMD_LOAD_TEX, 4'hF, 4'hF, 4'hF, SIDE_BAD_LO, 1'b1, 8'h01, 8'hAA);
      send_cmd(CMD_LOAD_NBR, 4'h0, 4'h5, 4'h0, SIDE_BAD_HI, 1'b0, 8'hFF, 8'hAA);
      // unknown commands do nothing
      send_cmd(CMD_RSVD_LO, 4'h0, 4'h5, 4'h0, SIDE_BAD_HI, 1'b0, 8'hFF, 8'hFF);
      send_cmd(CMD_RSVD_LO + 3'd1, 4'h0, 4'h0, 4'h0, SIDE_TOP, 1'b0, 8'h00, 8'h00);
      send_cmd(CMD_RSVD_HI, 4'hA, 4'h5, 4'hA, SIDE_RIGHT, 1'b0, 8'hA5, 8'h5A);
      send_random_fields(CMD_RESTART);
      for (int i = 0; i < EDGE_N; i++) send_random_fields(CMD_MESH);
      write_neighbors(6'h00);
      send_random_fields(CMD_RESTART);
      for (int i = 0; i < 8; i++) send_random_fields(CMD_MESH);
   endtask

   // reshuffle the column area, then mesh the whole column
   task automatic test_column_pass(input logic [NBR_W-1:0] nbr_cfg);
      write_neighbors(nbr_cfg);
      for (int i = 0; i < EDGE_N; i++)
         send_region_voxel($urandom_range(EDGE_N - 1), $urandom_range(2));
      send_random_fields(CMD_RESTART);
      for (int i = 0; i < EDGE_N; i++) send_random_fields(CMD_MESH);
   endtask

   // mostly mesh steps with loads, restarts and junk mixed in
   task automatic test_random_mix(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 58)      send_mesh_step();
         else if (pick < 74) send_region_voxel($urandom_range(EDGE_N - 1), $urandom_range(2));
         else if (pick < 82) send_random_fields(CMD_LOAD_NBR);
         else if (pick < 90) send_random_fields(CMD_LOAD_TEX);
         else if (pick < 93) send_random_fields(CMD_RESTART);
         else if (pick < 96)
            send_cmd(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), 4'($urandom),
                     4'($urandom), 4'($urandom), 3'($urandom_range(7)), 1'($urandom),
                     8'($urandom), 8'($urandom));
         else
            send_cmd(($urandom_range(1) != 0) ? CMD_LOAD_NBR : CMD_LOAD_TEX,
                     4'($urandom), 4'($urandom), 4'($urandom),
                     3'($urandom_range(SIDE_BAD_LO, SIDE_BAD_HI)), 1'($urandom),
                     8'($urandom), 8'($urandom));
      end
   endtask

   // receiver blocks for a long stretch while meshing continues, then sender waits
   task automatic test_backpressure();
      write_neighbors(6'h00);
      for (int y = 0; y < 4; y++)
         send_cmd(CMD_LOAD_VOXEL, 4'd0, 4'(y), 4'd0, SIDE_TOP, 1'b1,
                  8'($urandom_range(TYPES_USED - 1)), 8'h00);
      send_random_fields(CMD_RESTART);
      hold_stamp++;
      for (int i = 0; i < EDGE_N; i++) send_random_fields(CMD_MESH);
      drain_faces();
      send_random_fields(CMD_RESTART);
      for (int i = 0; i < 8; i++) send_random_fields(CMD_MESH);
   endtask

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (hold_stamp != hold_seen) begin
         hold_left = HOLD_LEN;
         hold_seen = hold_stamp;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // compare each face transfer with the oldest prediction
   always @(negedge clock) begin
      face_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_faces.size() == 0) begin
            report_mismatch("unexpected face", 1, 0);
         end else begin
            want = pending_faces.pop_front();
            if (rsp_chan.face_x !== want.fx) report_mismatch("face_x", rsp_chan.face_x, want.fx);
            if (rsp_chan.face_y !== want.fy) report_mismatch("face_y", rsp_chan.face_y, want.fy);
            if (rsp_chan.face_z !== want.fz) report_mismatch("face_z", rsp_chan.face_z, want.fz);
            if (rsp_chan.face_side !== want.fside)
               report_mismatch("face_side", rsp_chan.face_side, want.fside);
            if (rsp_chan.face_texture !== want.ftex)
               report_mismatch("face_texture", rsp_chan.face_texture, want.ftex);
            if (rsp_chan.face_number !== want.fnum)
               report_mismatch("face_number", rsp_chan.face_number, want.fnum);
            if (rsp_chan.last !== want.flast) report_mismatch("last", rsp_chan.last, want.flast);
            if (rsp_chan.done_res !== want.fdone)
               report_mismatch("done_res", rsp_chan.done_res, want.fdone);
            if (want.fdone) totals_seen++;
            else            faces_seen++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("Timeout: no transfer for %0d cycles", WDOG_MAX);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_RESTART;
      req_chan.x_pos      = '0;
      req_chan.y_pos      = '0;
      req_chan.z_pos      = '0;
      req_chan.side       = '0;
      req_chan.solid      = 1'b0;
      req_chan.block_type = '0;
      req_chan.texture    = '0;
      items_sent = 0;
      hold_stamp = 0;
      mesh_cursor = 0; face_tally = 0; nbr_present = '0;
      src_idle_pct = 34; sink_idle_pct = 66;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_store_fill();
      test_directed();
      test_column_pass(6'h3F);
      src_idle_pct = 66; sink_idle_pct = 34;
      test_column_pass(6'h00);
      test_random_mix(80);
      src_idle_pct = 0; sink_idle_pct = 0;
      test_column_pass(6'($urandom_range(1, 62)));
      test_random_mix(40);
      test_backpressure();
      drain_faces();

      $display("Sent %0d commands over column mesh passes, edge cases and mixed traffic;",
               items_sent);
      $display("checked %0d faces and %0d totals.", faces_seen, totals_seen);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/vfcm_pkg.sv
rtl/vfcm_req_if.sv
rtl/vfcm_rsp_if.sv
rtl/vfcm_ram.sv
rtl/vfcm_nbr_step.sv
rtl/voxel_face_culling_mesher_unit.sv
dv/tb.sv
